// ===== sv/infix_to_postfix_converter_core_macros.svh =====
// ----------------------------------------------------------------------------
// infix to postfix converter assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// condition holds at every edge out of reset
`define ITP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define ITP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// types, codes and the precedence table of the infix to postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int OP_W        = 4;
	localparam int VAL_W       = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// operator codes
	localparam logic [OP_W-1:0] OP_PLUS   = 4'd0;
	localparam logic [OP_W-1:0] OP_MINUS  = 4'd1;
	localparam logic [OP_W-1:0] OP_TIMES  = 4'd2;
	localparam logic [OP_W-1:0] OP_DIVIDE = 4'd3;
	localparam logic [OP_W-1:0] OP_OPEN   = 4'd4;
	localparam logic [OP_W-1:0] OP_CLOSE  = 4'd5;
	localparam logic [OP_W-1:0] OP_END    = 4'd6;
	localparam logic [OP_W-1:0] OP_NEGATE = 4'd7;
	localparam logic [OP_W-1:0] OP_ASSIGN = 4'd8;

	// token classes beyond the operator codes
	localparam logic [OP_W-1:0] CLASS_OPERAND = 4'd9;
	localparam logic [OP_W-1:0] CLASS_START   = 4'd10;

	// result kinds
	localparam logic [1:0] KIND_OPERAND  = 2'd0;
	localparam logic [1:0] KIND_OPERATOR = 2'd1;
	localparam logic [1:0] KIND_END      = 2'd2;
	localparam logic [1:0] KIND_ERROR    = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_CLASH    = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	typedef enum logic [1:0] {
		PR_HIGH,
		PR_LOW,
		PR_SAME,
		PR_ERR
	} prec_t;

	typedef enum logic {
		BK_EVAL,
		BK_LOAD
	} back_state_t;

	typedef struct packed {
		logic              opcode;
		logic [OP_W-1:0]   tok;
		logic [VAL_W-1:0]  operand_value;
	} queue_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [OP_W-1:0]  top;
		logic             hold;
		logic             emit;
		logic             loading;
	} back_status_t;

	// rows: top of stack, columns: arriving operator
	localparam prec_t PREC_TABLE [0:8][0:8] = '{
		'{PR_HIGH, PR_HIGH, PR_LOW,  PR_LOW,  PR_LOW, PR_HIGH, PR_HIGH, PR_LOW, PR_ERR},
		'{PR_HIGH, PR_HIGH, PR_LOW,  PR_LOW,  PR_LOW, PR_HIGH, PR_HIGH, PR_LOW, PR_ERR},
		'{PR_HIGH, PR_HIGH, PR_HIGH, PR_HIGH, PR_LOW, PR_HIGH, PR_HIGH, PR_LOW, PR_ERR},
		'{PR_HIGH, PR_HIGH, PR_HIGH, PR_HIGH, PR_LOW, PR_HIGH, PR_HIGH, PR_LOW, PR_ERR},
		'{PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW, PR_SAME, PR_ERR,  PR_LOW, PR_LOW},
		'{PR_HIGH, PR_HIGH, PR_HIGH, PR_HIGH, PR_ERR, PR_HIGH, PR_HIGH, PR_ERR, PR_ERR},
		'{PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW, PR_ERR,  PR_SAME, PR_LOW, PR_LOW},
		'{PR_HIGH, PR_HIGH, PR_HIGH, PR_HIGH, PR_LOW, PR_HIGH, PR_HIGH, PR_LOW, PR_ERR},
		'{PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW,  PR_LOW, PR_ERR,  PR_HIGH, PR_LOW, PR_LOW}
	};

	function automatic prec_t prec_lookup(input logic [OP_W-1:0] top,
			input logic [OP_W-1:0] tok);
		prec_t pr;
		if (top > OP_ASSIGN || tok > OP_ASSIGN) begin
			pr = PR_ERR;
		end else begin
			pr = PREC_TABLE[top][tok];
		end
		return pr;
	endfunction

endpackage

// ===== sv/itp_token_if.sv =====
// ----------------------------------------------------------------------------
// itp_token_if
// infix token channel: valid, ready and one token per beat
// ----------------------------------------------------------------------------
interface itp_token_if;
	import itp_pkg::*;

	logic             valid;
	logic             ready;
	logic             opcode;
	logic [OP_W-1:0]  operator_code;
	logic [VAL_W-1:0] operand_value;

	modport source (output valid, output opcode, output operator_code,
		output operand_value, input ready);
	modport sink (input valid, input opcode, input operator_code,
		input operand_value, output ready);
endinterface

// ===== sv/itp_postfix_if.sv =====
// ----------------------------------------------------------------------------
// itp_postfix_if
// postfix result channel: valid, ready and one result item per beat
// ----------------------------------------------------------------------------
interface itp_postfix_if;
	import itp_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       item_kind;
	logic [OP_W-1:0]  out_operator;
	logic [VAL_W-1:0] out_operand;
	logic [1:0]       error_code;
	logic             last_of_run;

	modport source (output valid, output item_kind, output out_operator,
		output out_operand, output error_code, output last_of_run, input ready);
	modport sink (input valid, input item_kind, input out_operator,
		input out_operand, input error_code, input last_of_run, output ready);
endinterface

// ===== sv/infix_to_postfix_converter_core.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// operator precedence infix to postfix conversion with an operator stack
// ----------------------------------------------------------------------------
//  channel   dir   beat
//  tokens    in    opcode, operator_code, operand_value
//  postfix   out   item_kind, out_operator, out_operand, error_code, last_of_run
//
// operands and pushes are handled in the eval state alone; matched parens
// also pass through the load state (pop and stack ram read), and so does
// every popped operator. a token that pops entries stays at the queue head
// until it ends in a push, a match, an end beat or an error.
// reset leaves the end marker on the stack; no clearing pass is needed.
// a stalled output beat holds the engine; the token queue keeps intake going.
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_core_macros.svh"

module infix_to_postfix_converter_core (
	input  logic          clk,
	input  logic          arst_n,
	itp_token_if.sink     tokens,
	itp_postfix_if.source postfix
);
	import itp_pkg::*;

	logic          push;
	queue_entry_t  push_data;
	logic          queue_full;
	logic          head_valid;
	queue_entry_t  head;
	logic          head_pop;
	back_status_t  status;
	logic          count_ok;
	logic          at_base;

	itp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tokens     (tokens),
		.queue_full (queue_full),
		.push       (push),
		.push_data  (push_data)
	);

	itp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (head_pop)
	);

	itp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.postfix    (postfix),
		.status     (status)
	);

	assign count_ok = status.count >= CNT_W'(1) && status.count <= CNT_W'(STACK_DEPTH);
	assign at_base  = !status.loading && status.count == CNT_W'(1);

	`ITP_ASSERT_ALWAYS(a_count_range, count_ok, "stack count out of range")
	`ITP_ASSERT_IMP(a_base_marker, at_base, status.top == OP_END, "stack base lost end marker")
	`ITP_ASSERT_IMP(a_hold_quiet, status.hold, !status.emit, "result produced while dropping tokens")
endmodule

// ===== sv/itp_ram.sv =====
// ----------------------------------------------------------------------------
// itp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module itp_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/itp_front.sv =====
// ----------------------------------------------------------------------------
// itp_front
// token intake: tracks the previous token class and turns unary minus
// into negate before queueing
// ----------------------------------------------------------------------------
module itp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	itp_token_if.sink            tokens,
	input  logic                 queue_full,
	output logic                 push,
	output itp_pkg::queue_entry_t push_data
);
	import itp_pkg::*;

	logic [OP_W-1:0] class_q;
	logic            unary;
	logic [OP_W-1:0] tok;

	assign tokens.ready = !queue_full;
	assign push         = tokens.valid && !queue_full;

	always_comb begin
		unary = class_q inside {CLASS_START, [OP_PLUS:OP_DIVIDE], OP_OPEN, OP_ASSIGN};
		tok   = tokens.operator_code;
		if (tokens.operator_code == OP_MINUS && unary) begin
			tok = OP_NEGATE;
		end
		push_data.opcode        = tokens.opcode;
		push_data.tok           = tok;
		push_data.operand_value = tokens.operand_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_START;
		end else if (push) begin
			if (!tokens.opcode) begin
				class_q <= CLASS_OPERAND;
			end else if (tok == OP_END) begin
				class_q <= CLASS_START;
			end else begin
				class_q <= tok;
			end
		end
	end
endmodule

// ===== sv/itp_queue.sv =====
// ----------------------------------------------------------------------------
// itp_queue
// short token queue between the intake and the stack engine
// ----------------------------------------------------------------------------
module itp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  itp_pkg::queue_entry_t push_data,
	output logic                  full,
	output logic                  head_valid,
	output itp_pkg::queue_entry_t head,
	input  logic                  pop
);
	import itp_pkg::*;

	queue_entry_t      entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   used_q;
	logic              do_pop;

	assign full       = used_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = used_q != '0;
	assign head       = entries[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			used_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !do_pop) begin
				used_q <= used_q + (QPTR_W+1)'(1);
			end else if (do_pop && !push) begin
				used_q <= used_q - (QPTR_W+1)'(1);
			end
		end
	end
endmodule

// ===== sv/itp_back.sv =====
// ----------------------------------------------------------------------------
// itp_back
// stack engine: operator stack in ram with the top in a register, pops one
// entry per pass and drives the postfix output register
// ----------------------------------------------------------------------------
module itp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  itp_pkg::queue_entry_t head,
	output logic                  head_pop,
	itp_postfix_if.source         postfix,
	output itp_pkg::back_status_t status
);
	import itp_pkg::*;

	back_state_t      state_q, state_d;
	logic [OP_W-1:0]  top_q, top_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             hold_q, hold_d;
	logic             pend_valid_q, pend_valid_d;
	logic [OP_W-1:0]  pend_op_q, pend_op_d;

	logic             out_valid_q;
	logic [1:0]       out_kind_q;
	logic [OP_W-1:0]  out_op_q;
	logic [VAL_W-1:0] out_opd_q;
	logic [1:0]       out_err_q;
	logic             out_last_q;

	logic             emit;
	logic [1:0]       e_kind;
	logic [OP_W-1:0]  e_op;
	logic [VAL_W-1:0] e_opd;
	logic [1:0]       e_err;
	logic             e_last;

	logic             can_emit;
	logic             stack_full;
	logic             quiet;
	prec_t            pr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [OP_W-1:0]   ram_rdata;

	itp_ram #(
		.WIDTH (OP_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (head.tok),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// read address always points at the entry under the top
	assign ram_waddr  = count_q[ADDR_W-1:0];
	assign ram_raddr  = ADDR_W'(count_q - CNT_W'(2));
	assign can_emit   = !out_valid_q || postfix.ready;
	assign stack_full = count_q >= CNT_W'(STACK_DEPTH);
	assign pr         = prec_lookup(top_q, head.tok);
	// outcomes that leave no result of their own
	assign quiet      = (pr == PR_LOW && !stack_full)
		|| (pr == PR_SAME && head.tok != OP_END);

	always_comb begin
		state_d      = state_q;
		top_d        = top_q;
		count_d      = count_q;
		hold_d       = hold_q;
		pend_valid_d = pend_valid_q;
		pend_op_d    = pend_op_q;
		head_pop     = 1'b0;
		ram_we       = 1'b0;
		emit         = 1'b0;
		e_kind       = KIND_OPERAND;
		e_op         = '0;
		e_opd        = '0;
		e_err        = ERR_NONE;
		e_last       = 1'b0;
		case (state_q)
			BK_LOAD: begin
				top_d   = (count_q == CNT_W'(1)) ? OP_END : ram_rdata;
				state_d = BK_EVAL;
			end
			BK_EVAL: begin
				if (head_valid) begin
					if (!head.opcode) begin
						if (hold_q) begin
							head_pop = 1'b1;
						end else if (can_emit) begin
							emit     = 1'b1;
							e_kind   = KIND_OPERAND;
							e_opd    = head.operand_value;
							e_last   = 1'b1;
							head_pop = 1'b1;
						end
					end else if (hold_q) begin
						head_pop = 1'b1;
						if (head.tok == OP_END) begin
							hold_d  = 1'b0;
							count_d = CNT_W'(1);
							top_d   = OP_END;
						end
					end else if (pr == PR_HIGH) begin
						if (!pend_valid_q || can_emit) begin
							if (pend_valid_q) begin
								emit   = 1'b1;
								e_kind = KIND_OPERATOR;
								e_op   = pend_op_q;
							end
							pend_valid_d = 1'b1;
							pend_op_d    = top_q;
							count_d      = count_q - CNT_W'(1);
							state_d      = BK_LOAD;
						end
					end else if (quiet) begin
						if (!pend_valid_q || can_emit) begin
							if (pend_valid_q) begin
								emit         = 1'b1;
								e_kind       = KIND_OPERATOR;
								e_op         = pend_op_q;
								e_last       = 1'b1;
								pend_valid_d = 1'b0;
							end
							head_pop = 1'b1;
							if (pr == PR_LOW) begin
								ram_we  = 1'b1;
								top_d   = head.tok;
								count_d = count_q + CNT_W'(1);
							end else begin
								count_d = count_q - CNT_W'(1);
								state_d = BK_LOAD;
							end
						end
					end else if (can_emit) begin
						emit = 1'b1;
						if (pend_valid_q) begin
							e_kind       = KIND_OPERATOR;
							e_op         = pend_op_q;
							pend_valid_d = 1'b0;
						end else begin
							head_pop = 1'b1;
							e_last   = 1'b1;
							if (pr == PR_SAME) begin
								e_kind  = KIND_END;
								count_d = CNT_W'(1);
								top_d   = OP_END;
							end else begin
								e_kind = KIND_ERROR;
								e_err  = (pr == PR_LOW) ? ERR_OVERFLOW : ERR_CLASH;
								if (head.tok == OP_END) begin
									count_d = CNT_W'(1);
									top_d   = OP_END;
								end else begin
									hold_d = 1'b1;
								end
							end
						end
					end
				end
			end
			default: begin
				state_d = BK_EVAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_EVAL;
			top_q        <= OP_END;
			count_q      <= CNT_W'(1);
			hold_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			top_q        <= top_d;
			count_q      <= count_d;
			hold_q       <= hold_d;
			pend_valid_q <= pend_valid_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (postfix.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_op_q <= pend_op_d;
		if (emit) begin
			out_kind_q <= e_kind;
			out_op_q   <= e_op;
			out_opd_q  <= e_opd;
			out_err_q  <= e_err;
			out_last_q <= e_last;
		end
	end

	assign postfix.valid        = out_valid_q;
	assign postfix.item_kind    = out_kind_q;
	assign postfix.out_operator = out_op_q;
	assign postfix.out_operand  = out_opd_q;
	assign postfix.error_code   = out_err_q;
	assign postfix.last_of_run  = out_last_q;

	assign status.count   = count_q;
	assign status.top     = top_q;
	assign status.hold    = hold_q;
	assign status.emit    = emit;
	assign status.loading = state_q == BK_LOAD;
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for infix_to_postfix_converter_core: infix tokens go in
// over the token channel, and a local operator stack model predicts every
// postfix beat, which is compared field by field as the beat leaves the block
// ----------------------------------------------------------------------------
module tb;
	import itp_pkg::*;

	localparam logic TOKEN_OPERAND  = 1'b0;
	localparam logic TOKEN_OPERATOR = 1'b1;
	localparam int   TOTAL_TOKENS   = 130;
	localparam int   DRAIN_CYCLES   = 100;

	typedef enum logic [1:0] {
		ACT_POP,
		ACT_PUSH,
		ACT_MATCH,
		ACT_CLASH
	} stack_action_t;

	typedef struct packed {
		logic             opcode;
		logic [OP_W-1:0]  code;
		logic [VAL_W-1:0] value;
	} token_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] operand;
		logic [1:0]       err;
		logic             last;
	} postfix_beat_t;

	class postfix_tracker;
		logic [OP_W-1:0] op_stack [STACK_DEPTH];
		int              depth;
		logic [OP_W-1:0] prev_class;
		bit              dropping;
		postfix_beat_t   due[$];
		int              mismatches;
		int              tokens_seen;
		int              tokens_dropped;
		int              beats_seen;
		int              error_beats;
		int              end_beats;

		function new();
			clear_stack();
			dropping = 0;
			mismatches = 0;
			tokens_seen = 0;
			tokens_dropped = 0;
			beats_seen = 0;
			error_beats = 0;
			end_beats = 0;
		endfunction

		function void clear_stack();
			foreach (op_stack[i]) op_stack[i] = OP_PLUS;
			op_stack[0] = OP_END;
			depth = 1;
			prev_class = CLASS_START;
		endfunction

		function stack_action_t action(input logic [OP_W-1:0] top,
				input logic [OP_W-1:0] tok);
			stack_action_t a;
			case (top)
			OP_PLUS, OP_MINUS: begin
				if (tok == OP_ASSIGN) a = ACT_CLASH;
				else if (tok == OP_TIMES || tok == OP_DIVIDE || tok == OP_OPEN ||
						tok == OP_NEGATE) a = ACT_PUSH;
				else a = ACT_POP;
			end
			OP_TIMES, OP_DIVIDE, OP_NEGATE: begin
				if (tok == OP_ASSIGN) a = ACT_CLASH;
				else if (tok == OP_OPEN || tok == OP_NEGATE) a = ACT_PUSH;
				else a = ACT_POP;
			end
			OP_OPEN: begin
				if (tok == OP_CLOSE) a = ACT_MATCH;
				else if (tok == OP_END) a = ACT_CLASH;
				else a = ACT_PUSH;
			end
			OP_CLOSE: begin
				if (tok == OP_OPEN || tok == OP_NEGATE || tok == OP_ASSIGN) a = ACT_CLASH;
				else a = ACT_POP;
			end
			OP_END: begin
				if (tok == OP_CLOSE) a = ACT_CLASH;
				else if (tok == OP_END) a = ACT_MATCH;
				else a = ACT_PUSH;
			end
			OP_ASSIGN: begin
				if (tok == OP_CLOSE) a = ACT_CLASH;
				else if (tok == OP_END) a = ACT_POP;
				else a = ACT_PUSH;
			end
			default: a = ACT_CLASH;
			endcase
			return a;
		endfunction

		function postfix_beat_t make_beat(input logic [1:0] kind,
				input logic [OP_W-1:0] op, input logic [VAL_W-1:0] operand,
				input logic [1:0] err);
			postfix_beat_t b;
			b.kind = kind;
			b.op = op;
			b.operand = operand;
			b.err = err;
			b.last = 1'b0;
			return b;
		endfunction

		// an error on the end token itself recovers at once
		function postfix_beat_t error_beat(input logic [1:0] err,
				input logic [OP_W-1:0] tok);
			if (tok == OP_END) begin
				clear_stack();
				dropping = 0;
			end else begin
				dropping = 1;
			end
			return make_beat(KIND_ERROR, OP_PLUS, '0, err);
		endfunction

		// returns 0 when the token is swallowed while recovering from an error
		function bit note_token(input token_t t);
			postfix_beat_t   produced[$];
			postfix_beat_t   b;
			logic [OP_W-1:0] tok;
			logic [OP_W-1:0] top;
			bit              busy;
			tokens_seen++;
			if (dropping) begin
				tokens_dropped++;
				if (t.opcode == TOKEN_OPERATOR && t.code == OP_END) begin
					clear_stack();
					dropping = 0;
				end
				return 0;
			end
			if (t.opcode == TOKEN_OPERAND) begin
				produced.push_back(make_beat(KIND_OPERAND, OP_PLUS, t.value, ERR_NONE));
				prev_class = CLASS_OPERAND;
			end else begin
				tok = t.code;
				if (tok == OP_MINUS && (prev_class == CLASS_START ||
						prev_class <= OP_DIVIDE || prev_class == OP_OPEN ||
						prev_class == OP_ASSIGN)) tok = OP_NEGATE;
				busy = 1;
				if (tok > OP_ASSIGN) begin
					produced.push_back(error_beat(ERR_CLASH, tok));
					busy = 0;
				end
				while (busy) begin
					top = (depth == 0 || depth > STACK_DEPTH) ? OP_END : op_stack[depth-1];
					busy = 0;
					case (action(top, tok))
					ACT_POP: begin
						produced.push_back(make_beat(KIND_OPERATOR, top, '0, ERR_NONE));
						if (depth > 0) depth--;
						busy = 1;
					end
					ACT_CLASH: produced.push_back(error_beat(ERR_CLASH, tok));
					ACT_PUSH: begin
						if (depth >= STACK_DEPTH) begin
							produced.push_back(error_beat(ERR_OVERFLOW, tok));
						end else begin
							op_stack[depth] = tok;
							depth++;
							prev_class = tok;
						end
					end
					default: begin
						if (tok == OP_END) begin
							produced.push_back(make_beat(KIND_END, OP_PLUS, '0, ERR_NONE));
							clear_stack();
						end else begin
							if (depth > 0) depth--;
							prev_class = tok;
						end
					end
					endcase
				end
			end
			foreach (produced[i]) begin
				b = produced[i];
				b.last = (i == produced.size() - 1);
				due.push_back(b);
			end
			return 1;
		endfunction

		task report(input string what);
			mismatches++;
			$display("mismatch at %0t ns: %s", $time, what);
		endtask

		task check_beat(input postfix_beat_t got);
			postfix_beat_t want;
			beats_seen++;
			if (got.kind == KIND_ERROR) error_beats++;
			if (got.kind == KIND_END) end_beats++;
			if (due.size() == 0) begin
				report($sformatf("beat %0d with nothing due: kind %0d op %0d operand %h err %0d",
					beats_seen, got.kind, got.op, got.operand, got.err));
				return;
			end
			want = due.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("beat %0d item_kind %0d, want %0d", beats_seen, got.kind, want.kind));
			if (got.op !== want.op)
				report($sformatf("beat %0d out_operator %0d, want %0d", beats_seen, got.op, want.op));
			if (got.operand !== want.operand)
				report($sformatf("beat %0d out_operand %h, want %h", beats_seen, got.operand,
					want.operand));
			if (got.err !== want.err)
				report($sformatf("beat %0d error_code %0d, want %0d", beats_seen, got.err, want.err));
			if (got.last !== want.last)
				report($sformatf("beat %0d last_of_run %0d, want %0d", beats_seen, got.last,
					want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	itp_token_if   tokens();
	itp_postfix_if postfix();

	infix_to_postfix_converter_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.tokens(tokens),
		.postfix(postfix)
	);

	postfix_tracker track;
	bit             idle_en;
	int             counted;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("** infix_to_postfix_converter_core: FAILED **");
		$finish;
	end

	task automatic send_token(input logic opc, input logic [OP_W-1:0] code,
			input logic [VAL_W-1:0] value);
		token_t t;
		int     gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			tokens.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tokens.valid <= 1'b1;
		tokens.opcode <= opc;
		tokens.operator_code <= code;
		tokens.operand_value <= value;
		do @(posedge clk); while (tokens.ready !== 1'b1);
		t.opcode = opc;
		t.code = code;
		t.value = value;
		void'(track.note_token(t));
		counted++;
	endtask

	function automatic token_t operand_token(input logic [VAL_W-1:0] value);
		token_t t;
		t.opcode = TOKEN_OPERAND;
		t.code = OP_W'($urandom_range(0, 15));
		t.value = value;
		return t;
	endfunction

	function automatic token_t op_token(input logic [OP_W-1:0] code);
		token_t t;
		t.opcode = TOKEN_OPERATOR;
		t.code = code;
		t.value = $urandom();
		return t;
	endfunction

	task automatic send_list(input token_t q[$]);
		foreach (q[i]) send_token(q[i].opcode, q[i].code, q[i].value);
	endtask

	task automatic operand(input logic [VAL_W-1:0] value);
		send_list('{operand_token(value)});
	endtask

	task automatic operator(input logic [OP_W-1:0] code);
		send_list('{op_token(code)});
	endtask

	// mostly well-formed expressions, now and then with one token spoiled
	task automatic random_expression();
		token_t q[$];
		token_t junk;
		int     operands;
		int     parens;
		int     pick;
		int     pos;
		operands = $urandom_range(1, 6);
		parens = 0;
		if ($urandom_range(0, 3) == 0) begin
			q.push_back(operand_token($urandom()));
			q.push_back(op_token(OP_ASSIGN));
		end
		for (int i = 0; i < operands; i++) begin
			while (parens < 4 && $urandom_range(0, 3) == 0) begin
				q.push_back(op_token(OP_OPEN));
				parens++;
			end
			pick = $urandom_range(0, 5);
			if (pick == 0) q.push_back(op_token(OP_MINUS));
			else if (pick == 1) q.push_back(op_token(OP_NEGATE));
			q.push_back(operand_token($urandom()));
			while (parens > 0 && $urandom_range(0, 2) == 0) begin
				q.push_back(op_token(OP_CLOSE));
				parens--;
			end
			if (i < operands - 1)
				q.push_back(op_token(OP_W'($urandom_range(OP_PLUS, OP_DIVIDE))));
		end
		while (parens > 0) begin
			q.push_back(op_token(OP_CLOSE));
			parens--;
		end
		q.push_back(op_token(OP_END));
		if ($urandom_range(0, 4) == 0) begin
			junk.opcode = 1'($urandom_range(0, 1));
			junk.code = OP_W'($urandom_range(0, 15));
			junk.value = $urandom();
			pos = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 2))
			0: q[pos] = junk;
			1: q.insert(pos, junk);
			default: q.delete(pos);
			endcase
		end
		send_list(q);
	endtask

	initial begin
		int stall_left;
		postfix_beat_t seen;
		stall_left = 0;
		postfix.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (postfix.valid === 1'b1 && postfix.ready === 1'b1) begin
				seen.kind = postfix.item_kind;
				seen.op = postfix.out_operator;
				seen.operand = postfix.out_operand;
				seen.err = postfix.error_code;
				seen.last = postfix.last_of_run;
				track.check_beat(seen);
			end
			if (stall_left > 0) begin
				stall_left--;
				postfix.ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				postfix.ready <= 1'b0;
			end else begin
				postfix.ready <= 1'b1;
			end
		end
	end

	initial begin
		token_t noise;
		int     n;
		track = new();
		idle_en = 1;
		counted = 0;
		arst_n <= 1'b0;
		tokens.valid <= 1'b0;
		tokens.opcode <= TOKEN_OPERAND;
		tokens.operator_code <= OP_PLUS;
		tokens.operand_value <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// unary minus at start, after times and open, binary after close and negate
		operator(OP_MINUS);
		operand(32'h0000_0000);
		operator(OP_TIMES);
		operator(OP_MINUS);
		operand(32'hffff_ffff);
		operator(OP_DIVIDE);
		operator(OP_OPEN);
		operator(OP_MINUS);
		operand($urandom());
		operator(OP_CLOSE);
		operator(OP_MINUS);
		operator(OP_NEGATE);
		operator(OP_MINUS);
		operand($urandom());
		operator(OP_END);

		// unary after assign, then a clash found after a pop; tokens dropped to end
		operand($urandom());
		operator(OP_ASSIGN);
		operator(OP_MINUS);
		operand($urandom());
		operator(OP_PLUS);
		operand($urandom());
		operator(OP_CLOSE);
		operator(OP_END);

		// close with assign on top
		operator(OP_OPEN);
		operator(OP_ASSIGN);
		operator(OP_CLOSE);
		operator(OP_END);

		// undefined operator code, then end token that hits an open paren
		operator(4'd15);
		operator(OP_END);
		operator(OP_OPEN);
		operator(OP_END);

		// deepest stack emptied by one end token, then a push past the top
		repeat (STACK_DEPTH - 1) operator(OP_NEGATE);
		operand($urandom());
		operator(OP_END);
		repeat (STACK_DEPTH) operator(OP_OPEN);
		operand($urandom());
		operator(OP_END);

		while (counted < TOTAL_TOKENS) begin
			if (counted > TOTAL_TOKENS * 4 / 5) idle_en = 0;
			else idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 7) == 0) begin
				n = $urandom_range(2, 6);
				repeat (n) begin
					noise.opcode = 1'($urandom_range(0, 1));
					noise.code = OP_W'($urandom_range(0, 15));
					noise.value = $urandom();
					send_list('{noise});
				end
				operator(OP_END);
			end else begin
				random_expression();
			end
		end
		tokens.valid <= 1'b0;

		while (track.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d tokens, %0d of them swallowed while recovering from errors",
			track.tokens_seen, track.tokens_dropped);
		$display("checked %0d postfix beats, %0d closing an expression and %0d reporting errors",
			track.beats_seen, track.end_beats, track.error_beats);
		if (track.mismatches == 0) begin
			$display("** infix_to_postfix_converter_core: PASSED **");
		end else begin
			$display("** infix_to_postfix_converter_core: FAILED **");
		end
		$finish;
	end
endmodule
